// ----- sv/bapaf_pkg.sv -----
package bapaf_pkg;

  // accept list geometry
  localparam int ACCEPT_DEPTH = 16;
  localparam int ACCEPT_IDX_W = (ACCEPT_DEPTH > 1) ? $clog2(ACCEPT_DEPTH) : 1;
  localparam int ACCEPT_CNT_W = 5;
  // wide enough for cell index, entry index and count in one compare
  localparam int CMP_W = (ACCEPT_IDX_W + 1 > ACCEPT_CNT_W) ? ACCEPT_IDX_W + 1 : ACCEPT_CNT_W;

  localparam int ADDR_W      = 48;
  localparam int ENTRY_IDX_W = 4;
  localparam int PDU_TYPE_W  = 4;
  localparam int PDU_LEN_W   = 6;
  localparam int ACTION_W    = 3;

  localparam int S_TDATA_W = 168;
  localparam int M_TDATA_W = 56;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_RANDOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADV_TYPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_COUNT = 3'd4;

  // link layer PDU types
  localparam logic [PDU_TYPE_W-1:0] PDU_ADV_IND        = 4'd0;
  localparam logic [PDU_TYPE_W-1:0] PDU_DIRECTED_ADV   = 4'd1;
  localparam logic [PDU_TYPE_W-1:0] PDU_SCAN_REQ       = 4'd3;
  localparam logic [PDU_TYPE_W-1:0] PDU_ADV_SCAN_IND   = 4'd6;
  localparam logic [PDU_LEN_W-1:0]  SCAN_REQ_LEN       = 6'd12;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic MODE_ADV  = 1'b0;

  // result actions
  localparam logic [ACTION_W-1:0] ACT_WRITTEN = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SEND    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ABORT   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CONNECT = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_REJECT  = 3'd5;

  // search key and running hit flag handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic              rnd;
    logic [ADDR_W-1:0] addr;
  } link_t;

  // accept list write, broadcast to every cell
  typedef struct packed {
    logic                   en;
    logic [ENTRY_IDX_W-1:0] idx;
    logic                   rnd;
    logic [ADDR_W-1:0]      addr;
  } wr_t;

endpackage

// ----- sv/bapaf_cell.sv -----
module bapaf_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bapaf_pkg::wr_t                       wr_i,
  input  logic [bapaf_pkg::ACCEPT_IDX_W-1:0]   cell_idx_i,
  input  logic [bapaf_pkg::ACCEPT_CNT_W-1:0]   cnt_i,
  input  bapaf_pkg::link_t                     link_i,
  output bapaf_pkg::link_t                     link_o
);

  logic [bapaf_pkg::ADDR_W-1:0] entry_addr_q;
  logic                         entry_rnd_q;
  logic                         vld_q;
  logic                         hit_q, hit_d;
  logic                         rnd_q;
  logic [bapaf_pkg::ADDR_W-1:0] addr_q;
  logic                         wr_sel;
  logic                         in_range;

  assign wr_sel = wr_i.en &&
                  (bapaf_pkg::CMP_W'(wr_i.idx) == bapaf_pkg::CMP_W'(cell_idx_i));
  assign in_range = bapaf_pkg::CMP_W'(cell_idx_i) < bapaf_pkg::CMP_W'(cnt_i);

  assign hit_d = link_i.hit |
                 (in_range && (link_i.rnd == entry_rnd_q) && (link_i.addr == entry_addr_q));

  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      entry_addr_q <= wr_i.addr;
      entry_rnd_q  <= wr_i.rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= link_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    rnd_q  <= link_i.rnd;
    addr_q <= link_i.addr;
  end

  assign link_o = '{vld: vld_q, hit: hit_q, rnd: rnd_q, addr: addr_q};

endmodule

// ----- sv/ble_adv_pdu_address_filter.sv -----
// Advertising-channel address filter. One word per input: s_axis_tuser 0
// writes an accept list slot, 1 presents a received PDU header and its two
// addresses. Every input word yields exactly one output word. An entry write,
// any advertising-mode PDU and an initiating-mode PDU that cannot qualify
// go straight from idle to the done state; there the result waits until the
// output register is free, moves into it, and the next word can be taken. An
// ADV_IND or directed advertising PDU in initiating mode first walks its
// sender address down the row of ACCEPT_DEPTH list cells, one cell per cycle,
// before it reaches the done state. One word is in work at a time; the next is
// taken as soon as the result sits in the output register, even if that is not
// yet taken. Configuration writes are always ready and must only be issued
// while the block is idle.
module ble_adv_pdu_address_filter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // cfg
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [bapaf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bapaf_pkg::ADDR_W-1:0]           cfg_data_i,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [3:0] entry_index, [51:4] entry_addr, [52] entry_random, [56:53] pdu_type,
  // [57] tx_flag, [58] rx_flag, [64:59] pdu_length, [112:65] first_addr,
  // [160:113] second_addr, [167:161] zero
  input  logic [bapaf_pkg::S_TDATA_W-1:0]        s_axis_tdata,
  // [0] req_type
  input  logic                                   s_axis_tuser,
  // output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [47:0] peer_addr, [48] peer_random, [55:49] zero
  output logic [bapaf_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // [2:0] action
  output logic [bapaf_pkg::ACTION_W-1:0]         m_axis_tuser
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_e;

  // unpacked input fields
  logic [bapaf_pkg::ENTRY_IDX_W-1:0] in_entry_index;
  logic [bapaf_pkg::ADDR_W-1:0]      in_entry_addr;
  logic                              in_entry_random;
  logic [bapaf_pkg::PDU_TYPE_W-1:0]  in_pdu_type;
  logic                              in_tx_flag;
  logic                              in_rx_flag;
  logic [bapaf_pkg::PDU_LEN_W-1:0]   in_pdu_length;
  logic [bapaf_pkg::ADDR_W-1:0]      in_first_addr;
  logic [bapaf_pkg::ADDR_W-1:0]      in_second_addr;

  assign in_entry_index  = s_axis_tdata[3:0];
  assign in_entry_addr   = s_axis_tdata[51:4];
  assign in_entry_random = s_axis_tdata[52];
  assign in_pdu_type     = s_axis_tdata[56:53];
  assign in_tx_flag      = s_axis_tdata[57];
  assign in_rx_flag      = s_axis_tdata[58];
  assign in_pdu_length   = s_axis_tdata[64:59];
  assign in_first_addr   = s_axis_tdata[112:65];
  assign in_second_addr  = s_axis_tdata[160:113];

  // configuration registers
  logic [bapaf_pkg::ADDR_W-1:0]       local_addr_q;
  logic                               local_random_q;
  logic                               filter_mode_q;
  logic [bapaf_pkg::PDU_TYPE_W-1:0]   own_adv_type_q;
  logic [bapaf_pkg::ACCEPT_CNT_W-1:0] accept_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q   <= '0;
      local_random_q <= 1'b0;
      filter_mode_q  <= 1'b0;
      own_adv_type_q <= '0;
      accept_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bapaf_pkg::CFG_LOCAL_ADDR:   local_addr_q   <= cfg_data_i;
        bapaf_pkg::CFG_LOCAL_RANDOM: local_random_q <= cfg_data_i[0];
        bapaf_pkg::CFG_FILTER_MODE:  filter_mode_q  <= cfg_data_i[0];
        bapaf_pkg::CFG_OWN_ADV_TYPE: own_adv_type_q <= cfg_data_i[bapaf_pkg::PDU_TYPE_W-1:0];
        bapaf_pkg::CFG_ACCEPT_COUNT: accept_count_q <= cfg_data_i[bapaf_pkg::ACCEPT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control and result registers
  state_e                           state_q, state_d;
  logic [bapaf_pkg::ACTION_W-1:0]   res_act_q, res_act_d;
  logic [bapaf_pkg::ADDR_W-1:0]     res_addr_q, res_addr_d;
  logic                             res_rnd_q, res_rnd_d;
  logic                             out_vld_q, out_vld_d;
  logic [bapaf_pkg::ACTION_W-1:0]   out_act_q, out_act_d;
  logic [bapaf_pkg::ADDR_W-1:0]     out_addr_q, out_addr_d;
  logic                             out_rnd_q, out_rnd_d;

  logic                             in_acc;
  logic                             adv_ok;
  logic                             aimed;
  logic                             can_connect;
  logic                             out_free;

  bapaf_pkg::wr_t                   wr;
  bapaf_pkg::link_t                 link [bapaf_pkg::ACCEPT_DEPTH+1];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign adv_ok = ((own_adv_type_q == bapaf_pkg::PDU_ADV_IND) ||
                   (own_adv_type_q == bapaf_pkg::PDU_ADV_SCAN_IND)) &&
                  (in_pdu_type == bapaf_pkg::PDU_SCAN_REQ);
  assign aimed  = (in_rx_flag == local_random_q) && (in_second_addr == local_addr_q);
  assign can_connect = (in_pdu_type == bapaf_pkg::PDU_ADV_IND) ||
                       ((in_pdu_type == bapaf_pkg::PDU_DIRECTED_ADV) && aimed);

  assign wr = '{en:   in_acc && (s_axis_tuser == bapaf_pkg::REQ_WRITE),
                idx:  in_entry_index,
                rnd:  in_entry_random,
                addr: in_entry_addr};

  // head of the row: launch the sender address as search key
  assign link[0] = '{vld:  in_acc && (s_axis_tuser != bapaf_pkg::REQ_WRITE) &&
                           (filter_mode_q != bapaf_pkg::MODE_ADV) && can_connect,
                     hit:  1'b0,
                     rnd:  in_tx_flag,
                     addr: in_first_addr};

  for (genvar k = 0; k < bapaf_pkg::ACCEPT_DEPTH; k++) begin : g_cell
    bapaf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_i       (wr),
      .cell_idx_i (bapaf_pkg::ACCEPT_IDX_W'(k)),
      .cnt_i      (accept_count_q),
      .link_i     (link[k]),
      .link_o     (link[k+1])
    );
  end

  always_comb begin
    state_d    = state_q;
    res_act_d  = res_act_q;
    res_addr_d = res_addr_q;
    res_rnd_d  = res_rnd_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_act_d  = out_act_q;
    out_addr_d = out_addr_q;
    out_rnd_d  = out_rnd_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_addr_d = '0;
          res_rnd_d  = 1'b0;
          state_d    = S_DONE;
          if (s_axis_tuser == bapaf_pkg::REQ_WRITE) begin
            res_act_d = bapaf_pkg::ACT_WRITTEN;
          end else if (filter_mode_q == bapaf_pkg::MODE_ADV) begin
            if (!adv_ok) begin
              res_act_d = bapaf_pkg::ACT_IGNORED;
            end else if ((in_pdu_length == bapaf_pkg::SCAN_REQ_LEN) && aimed) begin
              res_act_d = bapaf_pkg::ACT_SEND;
            end else begin
              res_act_d = bapaf_pkg::ACT_ABORT;
            end
          end else if (can_connect) begin
            state_d = S_SEARCH;
          end else begin
            res_act_d = bapaf_pkg::ACT_REJECT;
          end
        end
      end
      S_SEARCH: begin
        // key leaves the last cell with the OR of all in-range matches
        if (link[bapaf_pkg::ACCEPT_DEPTH].vld) begin
          state_d = S_DONE;
          if (link[bapaf_pkg::ACCEPT_DEPTH].hit) begin
            res_act_d  = bapaf_pkg::ACT_CONNECT;
            res_addr_d = link[bapaf_pkg::ACCEPT_DEPTH].addr;
            res_rnd_d  = link[bapaf_pkg::ACCEPT_DEPTH].rnd;
          end else begin
            res_act_d = bapaf_pkg::ACT_REJECT;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_act_d  = res_act_q;
          out_addr_d = res_addr_q;
          out_rnd_d  = res_rnd_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      res_act_q  <= bapaf_pkg::ACT_WRITTEN;
      res_addr_q <= '0;
      res_rnd_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      out_act_q  <= bapaf_pkg::ACT_WRITTEN;
      out_addr_q <= '0;
      out_rnd_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      res_act_q  <= res_act_d;
      res_addr_q <= res_addr_d;
      res_rnd_q  <= res_rnd_d;
      out_vld_q  <= out_vld_d;
      out_act_q  <= out_act_d;
      out_addr_q <= out_addr_d;
      out_rnd_q  <= out_rnd_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_act_q;
  assign m_axis_tdata  = {7'b0, out_rnd_q, out_addr_q};

endmodule

// ----- sv/bapaf_checker.sv -----
module bapaf_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   s_axis_tvalid,
  input logic                                   s_axis_tready,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [bapaf_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  input logic [bapaf_pkg::ACTION_W-1:0]         m_axis_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // only defined actions leave the block
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= bapaf_pkg::ACT_REJECT))
    else $error("undefined action code");

  // peer fields are zero unless connecting
  a_peer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != bapaf_pkg::ACT_CONNECT) |-> (m_axis_tdata == '0))
    else $error("peer data on non-connect action");

  // one word in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous word in work");

endmodule

bind ble_adv_pdu_address_filter bapaf_checker u_bapaf_checker (.*);
